// File: src/vca_pkg.sv
// Shared types and constants for the voice channel allocator.
// Used by vca_table, vca_cmp and voice_channel_allocator_unit; depends on nothing.
package vca_pkg;

    // Field widths fixed by the request and result words.
    localparam int REQ_W   = 2;
    localparam int ENT_W   = 16;
    localparam int SLOT_W  = 8;
    localparam int TIME_W  = 32;
    localparam int RIDX_W  = 6;
    localparam int CHIDX_W = 6;

    // Configuration registers.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CIU_W      = 7;
    localparam int MASK_BITS  = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_MASK   = 2'd1;

    localparam logic [CIU_W-1:0] CIU_RESET = 7'd64;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ALLOC       = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RELEASE     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE_ALL = 2'd2;

    // One channel's owner record as kept in the table memory.
    typedef struct packed {
        logic [ENT_W-1:0]  owner;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] start;
    } t_chan_rec;

    // Verdict of the compare unit on one channel.
    typedef struct packed {
        logic take;   // free channel or same owner and slot: stop the scan here
        logic older;  // active channel that started before the oldest seen so far
    } t_cmp_res;

endpackage

// File: src/vca_table.sv
// Channel owner table: owner entity, slot and start time per channel.
// One write port and one registered read port; uses vca_pkg.
module vca_table
    import vca_pkg::*;
#(
    parameter int NUM_CHANNELS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [$clog2(NUM_CHANNELS)-1:0] i_waddr,
    input  t_chan_rec                       i_wdata,
    input  logic [$clog2(NUM_CHANNELS)-1:0] i_raddr,
    output t_chan_rec                       o_rdata
);

    t_chan_rec r_mem [NUM_CHANNELS];
    t_chan_rec r_rdata;

    // Write when a channel is granted; read one entry every cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/vca_cmp.sv
// Shared compare unit: judges one channel entry against the pending request.
// Uses the record and verdict types of vca_pkg.
module vca_cmp
    import vca_pkg::*;
(
    input  t_chan_rec         i_rec,
    input  logic              i_active,
    input  logic              i_reserved,
    input  logic [ENT_W-1:0]  i_ent,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [TIME_W-1:0] i_oldest,
    output t_cmp_res          o_res
);

    logic owner_match;

    // A zero slot never claims an existing sound.
    assign owner_match = (i_slot != '0) && (i_rec.owner == i_ent) && (i_rec.slot == i_slot);

    // Reserved channels are never candidates.
    always_comb begin
        o_res.take  = !i_reserved && (!i_active || owner_match);
        o_res.older = !i_reserved && i_active && (i_rec.start < i_oldest);
    end

endmodule

// File: src/voice_channel_allocator_unit.sv
// Top level of the voice channel allocator: scan sequencer, active flags, result word.
// Depends on vca_pkg, vca_table and vca_cmp.
//
//  Channel   Handshake          Ports
//  -------   ----------------   -------------------------------------------------
//  request   start && !busy     i_req_type i_owner_entity i_owner_slot
//                               i_current_time i_release_index
//  result    o_done (1 cycle)   o_granted o_channel_index o_stolen
//  config    i_cfg_we           i_cfg_idx i_cfg_data
//
// Release, release-all and unused requests finish at the accepting edge; their result word
// shows in the next cycle and busy stays low. An allocate walks the owner table one entry
// a cycle through its single read port and the compare unit, up to the scan length; a free
// or matching channel ends the scan early.
// Synchronous active-low reset clears the active flags, restores the reset configuration and idles the sequencer.
// The receiver cannot stall: each result word is valid for exactly one cycle.
module voice_channel_allocator_unit
    import vca_pkg::*;
#(
    parameter int NUM_CHANNELS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [ENT_W-1:0]      i_owner_entity,
    input  logic [SLOT_W-1:0]     i_owner_slot,
    input  logic [TIME_W-1:0]     i_current_time,
    input  logic [RIDX_W-1:0]     i_release_index,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_done,
    output logic                  o_granted,
    output logic [CHIDX_W-1:0]    o_channel_index,
    output logic                  o_stolen
);

    localparam int IW = $clog2(NUM_CHANNELS);
    localparam int CW = IW + 1;
    localparam int LW = (CW > CIU_W) ? CW : CIU_W;
    localparam int EW = ((IW > RIDX_W) ? IW : RIDX_W) + 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_COMMIT = 2'd2;

    logic [1:0]              r_state;
    logic [CIU_W-1:0]        r_ciu;
    logic [MASK_BITS-1:0]    r_resv_mask;
    logic [NUM_CHANNELS-1:0] r_active;

    // Latched request word.
    logic [ENT_W-1:0]        r_ent;
    logic [SLOT_W-1:0]       r_slot;
    logic [TIME_W-1:0]       r_now;

    // Scan state.
    logic [CW-1:0]           r_idx;
    logic                    r_chk_vld;
    logic [IW-1:0]           r_chk_idx;
    logic [TIME_W-1:0]       r_oldest;
    logic [IW-1:0]           r_pick;
    logic                    r_found;

    // Result word.
    logic                    r_done;
    logic                    r_granted;
    logic [CHIDX_W-1:0]      r_chan;
    logic                    r_stolen;

    logic                    accept;
    logic [CW-1:0]           limit;
    logic                    issue;
    logic [EW-1:0]           chk_ext;
    logic                    chk_resv;
    logic                    rel_in_range;
    logic                    tbl_we;
    t_chan_rec               tbl_wdata;
    t_chan_rec               tbl_rdata;
    t_cmp_res                cmp_res;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // Scan length saturates at the table size.
    assign limit = (LW'(r_ciu) > LW'(NUM_CHANNELS)) ? CW'(NUM_CHANNELS) : CW'(r_ciu);
    assign issue = (r_idx < limit);

    // Only the first 64 channels have a reserve bit.
    assign chk_ext  = EW'(r_chk_idx);
    assign chk_resv = (chk_ext < EW'(MASK_BITS)) && r_resv_mask[chk_ext[RIDX_W-1:0]];

    assign rel_in_range = (LW'(i_release_index) < LW'(NUM_CHANNELS));

    // Table write when an allocate is granted.
    assign tbl_we          = (r_state == ST_COMMIT) && r_found;
    assign tbl_wdata.owner = r_ent;
    assign tbl_wdata.slot  = r_slot;
    assign tbl_wdata.start = r_now;

    vca_table #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (r_pick),
        .i_wdata (tbl_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (tbl_rdata)
    );

    vca_cmp u_cmp (
        .i_rec      (tbl_rdata),
        .i_active   (r_active[r_chk_idx]),
        .i_reserved (chk_resv),
        .i_ent      (r_ent),
        .i_slot     (r_slot),
        .i_oldest   (r_oldest),
        .o_res      (cmp_res)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ciu       <= CIU_RESET;
            r_resv_mask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHANNELS_IN_USE: r_ciu       <= i_cfg_data[CIU_W-1:0];
                CFG_RESERVED_MASK:   r_resv_mask <= i_cfg_data;
                default:             r_ciu       <= r_ciu;
            endcase
        end
    end

    // Sequencer, active flags and result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_active  <= '0;
            r_done    <= 1'b0;
            r_chk_vld <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_ent     <= i_owner_entity;
                        r_slot    <= i_owner_slot;
                        r_now     <= i_current_time;
                        r_oldest  <= i_current_time;
                        r_idx     <= '0;
                        r_chk_vld <= 1'b0;
                        r_found   <= 1'b0;
                        r_pick    <= '0;
                        r_granted <= 1'b0;
                        r_chan    <= '0;
                        r_stolen  <= 1'b0;
                        case (i_req_type)
                            REQ_ALLOC: begin
                                r_state <= ST_SCAN;
                            end
                            REQ_RELEASE: begin
                                if (rel_in_range) begin
                                    r_active[IW'(i_release_index)] <= 1'b0;
                                end
                                r_done <= 1'b1;
                            end
                            REQ_RELEASE_ALL: begin
                                r_active <= '0;
                                r_done   <= 1'b1;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    // Issue the next table read.
                    r_chk_vld <= issue;
                    r_chk_idx <= r_idx[IW-1:0];
                    if (issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    // Judge the entry whose data has arrived.
                    if (r_chk_vld && cmp_res.take) begin
                        r_pick  <= r_chk_idx;
                        r_found <= 1'b1;
                        r_state <= ST_COMMIT;
                    end else begin
                        if (r_chk_vld && cmp_res.older) begin
                            r_oldest <= tbl_rdata.start;
                            r_pick   <= r_chk_idx;
                            r_found  <= 1'b1;
                        end
                        if (!issue && !r_chk_vld) begin
                            r_state <= ST_COMMIT;
                        end
                    end
                end
                ST_COMMIT: begin
                    if (r_found) begin
                        r_granted        <= 1'b1;
                        r_chan           <= CHIDX_W'(r_pick);
                        r_stolen         <= r_active[r_pick];
                        r_active[r_pick] <= 1'b1;
                    end
                    r_done  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done          = r_done;
    assign o_granted       = r_granted;
    assign o_channel_index = r_chan;
    assign o_stolen        = r_stolen;

    // A word that is not a grant carries no channel and no steal.
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_granted) |-> (o_channel_index == '0) && !o_stolen)
        else $error("miss or release word carries a channel");

    // The scan pointer never runs past the scan length.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= limit))
        else $error("scan pointer past the scan length");

    // A granted channel is marked active when its word is shown.
    a_grant_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_granted) |-> r_active[r_pick])
        else $error("granted channel not active");

    // Every accepted word either starts a scan or is answered next cycle.
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && accept) |=> (busy || o_done))
        else $error("accepted word neither scanning nor answered");

endmodule

// File: verif/tb_voice_channel_allocator_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for voice_channel_allocator_unit: a queue-fed request driver, a result
// monitor and a local channel-table predictor whose result words are compared field by field.
// Depends on vca_pkg and the voice_channel_allocator_unit RTL.
module tb_voice_channel_allocator_unit;
    import vca_pkg::*;

    localparam int NUM_CH       = 64;
    localparam int SETTLE       = 4;
    localparam int DRAIN_CYCLES = 80;
    localparam int QUIET_LIMIT  = 2000;
    localparam int SHOWN_ERRORS = 10;

    // Codes the package leaves unnamed: the spare request type and the spare register index.
    localparam logic [REQ_W-1:0]     REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // One request word; hold makes the driver wait until every outstanding result has come.
    typedef struct {
        logic [REQ_W-1:0]  kind;
        logic [ENT_W-1:0]  ent;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] now;
        logic [RIDX_W-1:0] rel;
        bit                hold;
    } t_voice_req;

    // One result word.
    typedef struct packed {
        logic               granted;
        logic [CHIDX_W-1:0] idx;
        logic               stolen;
    } t_voice_res;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic [REQ_W-1:0]      i_req_type      = '0;
    logic [ENT_W-1:0]      i_owner_entity  = '0;
    logic [SLOT_W-1:0]     i_owner_slot    = '0;
    logic [TIME_W-1:0]     i_current_time  = '0;
    logic [RIDX_W-1:0]     i_release_index = '0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx       = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  o_done;
    logic                  o_granted;
    logic [CHIDX_W-1:0]    o_channel_index;
    logic                  o_stolen;

    // Predicted configuration and channel table.
    logic [CIU_W-1:0]     scan_len;
    logic [MASK_BITS-1:0] stream_mask;
    bit                   ch_on    [NUM_CH];
    logic [ENT_W-1:0]     ch_owner [NUM_CH];
    logic [SLOT_W-1:0]    ch_slot  [NUM_CH];
    logic [TIME_W-1:0]    ch_start [NUM_CH];

    t_voice_req        req_backlog [$];
    t_voice_res        grant_queue [$];
    t_voice_req        offered;
    bit                steady     = 1'b0;
    logic [TIME_W-1:0] frame      = '0;
    int                fail_count = 0;
    int                quiet      = 0;

    voice_channel_allocator_unit #(
        .NUM_CHANNELS(NUM_CH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_owner_entity (i_owner_entity),
        .i_owner_slot   (i_owner_slot),
        .i_current_time (i_current_time),
        .i_release_index(i_release_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_granted      (o_granted),
        .o_channel_index(o_channel_index),
        .o_stolen       (o_stolen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one request to the predicted table and returns the result word it should give.
    function automatic t_voice_res predict_grant(input t_voice_req r);
        t_voice_res        res;
        int                lim;
        int                pick;
        bit                found;
        logic [TIME_W-1:0] oldest;
        res = '0;
        case (r.kind)
            REQ_RELEASE: begin
                ch_on[r.rel] = 1'b0;
            end
            REQ_RELEASE_ALL: begin
                foreach (ch_on[i]) ch_on[i] = 1'b0;
            end
            REQ_ALLOC: begin
                lim    = (scan_len > NUM_CH) ? NUM_CH : int'(scan_len);
                oldest = r.now;
                pick   = 0;
                found  = 1'b0;
                // A free channel or the same owner and nonzero slot ends the scan; otherwise
                // remember the strictly oldest sound, the lowest index winning ties.
                for (int i = 0; i < lim; i++) begin
                    if (stream_mask[i]) continue;
                    if (!ch_on[i]) begin
                        pick  = i;
                        found = 1'b1;
                        break;
                    end
                    if (r.slot != '0 && ch_owner[i] == r.ent && ch_slot[i] == r.slot) begin
                        pick  = i;
                        found = 1'b1;
                        break;
                    end
                    if (ch_start[i] < oldest) begin
                        oldest = ch_start[i];
                        pick   = i;
                        found  = 1'b1;
                    end
                end
                if (found) begin
                    res.granted    = 1'b1;
                    res.idx        = pick[CHIDX_W-1:0];
                    res.stolen     = ch_on[pick];
                    ch_owner[pick] = r.ent;
                    ch_slot[pick]  = r.slot;
                    ch_start[pick] = r.now;
                    ch_on[pick]    = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Request driver: predicts each word as it is accepted and offers the next one.
    always @(posedge i_clk) begin : drive_requests
        bit         taken;
        bit         ready;
        t_voice_req nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                grant_queue.push_back(predict_grant(offered));
            end
            ready = taken || !start;
            if (ready && req_backlog.size() != 0
                    && !(req_backlog[0].hold && grant_queue.size() != 0)
                    && (steady || $urandom_range(99) >= 30)) begin
                nxt             = req_backlog.pop_front();
                offered         = nxt;
                start           <= 1'b1;
                i_req_type      <= nxt.kind;
                i_owner_entity  <= nxt.ent;
                i_owner_slot    <= nxt.slot;
                i_current_time  <= nxt.now;
                i_release_index <= nxt.rel;
            end else if (ready) begin
                // Idle cycle: the fields carry noise that must be ignored.
                start           <= 1'b0;
                i_req_type      <= REQ_W'($urandom);
                i_owner_entity  <= ENT_W'($urandom);
                i_owner_slot    <= SLOT_W'($urandom);
                i_current_time  <= $urandom;
                i_release_index <= RIDX_W'($urandom);
            end
        end
    end

    // Result monitor: every strobed word must match the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_voice_res got;
        t_voice_res want;
        if (i_rst_n && o_done) begin
            got = {o_granted, o_channel_index, o_stolen};
            if (grant_queue.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOWN_ERRORS) begin
                    $display({"mismatch: result word with none expected: ",
                              "granted=%0d idx=%0d stolen=%0d"},
                             got.granted, got.idx, got.stolen);
                end
            end else begin
                want = grant_queue.pop_front();
                if (got.granted !== want.granted || got.idx !== want.idx
                        || got.stolen !== want.stolen) begin
                    fail_count++;
                    if (fail_count <= SHOWN_ERRORS) begin
                        $display({"mismatch: expected granted=%0d idx=%0d stolen=%0d, ",
                                  "got granted=%0d idx=%0d stolen=%0d"},
                                 want.granted, want.idx, want.stolen,
                                 got.granted, got.idx, got.stolen);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either side ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("[voice_channel_allocator_unit] ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == CFG_CHANNELS_IN_USE) begin
            scan_len = data[CIU_W-1:0];
        end else if (idx == CFG_RESERVED_MASK) begin
            stream_mask = data;
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Waits until the backlog is sent and every predicted word has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        while (req_backlog.size() != 0 || grant_queue.size() != 0 || start) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push_req(input logic [REQ_W-1:0] kind, input logic [ENT_W-1:0] ent,
                            input logic [SLOT_W-1:0] slot, input logic [TIME_W-1:0] now,
                            input logic [RIDX_W-1:0] rel);
        t_voice_req r;
        r = '{kind, ent, slot, now, rel, 1'b0};
        req_backlog.push_back(r);
    endtask

    // One configuration setting followed by random requests. Entities and slots come mostly
    // from a small pool so that owner matches and full tables, hence steals, are common.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] ciu_word,
                             input logic [CFG_DATA_W-1:0] mask, input int count,
                             input bit calm, input logic [TIME_W-1:0] base);
        t_voice_req r;
        int         lim;
        int         roll;
        wait_idle();
        write_reg(CFG_CHANNELS_IN_USE, ciu_word);
        write_reg(CFG_RESERVED_MASK, mask);
        if (frame < base) frame = base;
        lim    = (scan_len == '0) ? 1 : ((scan_len > NUM_CH) ? NUM_CH : int'(scan_len));
        steady = calm;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 74 || roll >= 96) begin
                r.kind = REQ_ALLOC;
            end else if (roll < 92) begin
                r.kind = REQ_RELEASE;
            end else if (roll < 94) begin
                r.kind = REQ_RELEASE_ALL;
            end else begin
                r.kind = REQ_UNUSED;
            end
            r.ent = ($urandom_range(9) < 8) ? ENT_W'($urandom_range(7)) : ENT_W'($urandom);
            case ($urandom_range(4))
                0, 1, 2: r.slot = SLOT_W'($urandom_range(3));
                3:       r.slot = '1;
                default: r.slot = SLOT_W'($urandom);
            endcase
            r.rel = ($urandom_range(9) < 7) ? RIDX_W'($urandom_range(lim - 1))
                                            : RIDX_W'($urandom);
            // Time mostly creeps forward, sometimes stands still, now and then steps back.
            if ($urandom_range(19) == 0) begin
                r.now = frame - TIME_W'($urandom_range(50));
            end else begin
                frame = frame + TIME_W'($urandom_range(2));
                r.now = frame;
            end
            r.hold = ($urandom_range(49) == 0);
            req_backlog.push_back(r);
        end
    endtask

    initial begin
        scan_len    = CIU_RESET;
        stream_mask = '0;
        foreach (ch_on[i]) ch_on[i] = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset configuration: free channels, owner match, slot zero, releases, spare type.
        push_req(REQ_RELEASE_ALL, '0, '0, 32'd0, '0);
        push_req(REQ_ALLOC, 16'd0, 8'd0, 32'd0, '0);
        push_req(REQ_ALLOC, 16'hFFFF, 8'hFF, 32'd1, '0);
        push_req(REQ_ALLOC, 16'hFFFF, 8'hFF, 32'd2, '0);
        push_req(REQ_ALLOC, 16'd0, 8'd0, 32'd2, '0);
        push_req(REQ_RELEASE, '0, '0, 32'd2, 6'd0);
        push_req(REQ_ALLOC, 16'd5, 8'd1, 32'd3, '0);
        push_req(REQ_RELEASE, 16'hFFFF, 8'hFF, 32'd3, 6'd63);
        push_req(REQ_UNUSED, 16'hFFFF, 8'hFF, 32'd3, 6'd63);

        // Two channels: steal the oldest, miss when nothing is older, lowest index on a tie.
        wait_idle();
        write_reg(CFG_CHANNELS_IN_USE, 64'd2);
        push_req(REQ_RELEASE_ALL, '0, '0, 32'd10, '0);
        push_req(REQ_ALLOC, 16'd1, 8'd1, 32'd10, '0);
        push_req(REQ_ALLOC, 16'd2, 8'd1, 32'd11, '0);
        push_req(REQ_ALLOC, 16'd3, 8'd2, 32'd11, '0);
        push_req(REQ_ALLOC, 16'd4, 8'd1, 32'd11, '0);
        push_req(REQ_ALLOC, 16'd4, 8'd1, 32'd12, '0);

        // Reserved channels are skipped; with both reserved every allocate misses.
        wait_idle();
        write_reg(CFG_RESERVED_MASK, 64'h1);
        push_req(REQ_ALLOC, 16'd5, 8'd3, 32'd13, '0);
        wait_idle();
        write_reg(CFG_RESERVED_MASK, 64'h3);
        push_req(REQ_ALLOC, 16'd6, 8'd3, 32'd14, '0);
        frame = 32'd14;

        // A write to the spare register index must change nothing.
        wait_idle();
        write_reg(CFG_UNUSED, {$urandom, $urandom});

        run_phase(64'd1, 64'd0, 60, 1'b0, 32'd0);
        run_phase(64'd8, {$urandom, $urandom}, 200, 1'b0, 32'd0);
        run_phase(64'd64, 64'd0, 300, 1'b1, 32'h0000_0100);
        run_phase(64'd0, {$urandom, $urandom}, 30, 1'b0, 32'h0001_0000);
        run_phase(64'd127, 64'd0, 150, 1'b0, 32'h0001_0000);
        run_phase(64'd16, 64'hAAAA_AAAA_AAAA_AAAA, 150, 1'b0, 32'h7FFF_0000);
        run_phase(({$urandom, $urandom} & ~64'h7F) | 64'd64,
                  {$urandom, $urandom} & {$urandom, $urandom}, 200, 1'b0, 32'h8000_0000);
        run_phase(64'd64, '1, 20, 1'b0, 32'h8000_1000);
        run_phase(64'd5, 64'h8000_0000_0000_0001, 100, 1'b0, 32'hFFFF_FF00);
        push_req(REQ_ALLOC, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, '0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        fail_count += grant_queue.size();
        if (fail_count == 0) begin
            $display("[voice_channel_allocator_unit] OK");
        end else begin
            $display("[voice_channel_allocator_unit] ERROR");
        end
        $finish;
    end

endmodule

// File: voice_channel_allocator_unit.f
src/vca_pkg.sv
src/vca_table.sv
src/vca_cmp.sv
src/voice_channel_allocator_unit.sv
verif/tb_voice_channel_allocator_unit.sv
